// File: sv/ksdc_pkg.sv
// Shared widths and constants for the k-smallest distance cutoff unit.
package ksdc_pkg;

  localparam int COORD_W = 15;
  localparam int DIST_W  = 31;
  localparam int KEPT_W  = 11;
  localparam int SQ_W    = 2 * COORD_W;

  localparam logic [KEPT_W-1:0] KEEP_RESET = 11'd1024;

endpackage

// File: sv/k_smallest_distance_cutoff_unit.sv
// Top level: keeps the smallest squared distances in a max-heap held in RAM.
//
// Input requests carry two points (in_tdata) and a set marker (in_tlast).
// Each request yields exactly one result: the largest distance kept so far
// (the cutoff) and the count kept, with out_tlast copying the set marker.
// After the result of a marked request the heap is emptied.
// cfg_data sets keep_count (0 acts as 1, values above KEEP_MAX act as
// KEEP_MAX); it is always ready and should be written between sets.
// One request is in flight at a time. After accept the distance passes the
// difference, square and sum stages; it is then added if the heap is not
// full, replaces the top if below the cutoff, or else is dropped and goes
// straight to the output. A sift walks the heap one level per step (one RAM
// access with compare and write-back per level). in_tready is high only
// between requests: a request is taken the cycle after a result is registered.
// A result waits in the output register while the receiver stalls; the
// next request is processed meanwhile and holds only when its own result
// is ready. Synchronous active-low reset clears the count, sets
// keep_count to 1024 and empties the output register; RAM is not cleared.
module k_smallest_distance_cutoff_unit #(
  parameter int KEEP_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // ax[14:0], ay[29:15], bx[44:30], by[59:45], zero[63:60]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // cutoff_sq[30:0], kept[41:31], zero[47:42]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ksdc_pkg::KEPT_W-1:0] cfg_data
);
  import ksdc_pkg::*;

  localparam int AW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int SW = $clog2(KEEP_MAX + 1);
  localparam int CW = AW + 2;
  localparam int LW = (SW > KEPT_W) ? SW : KEPT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SUM, S_DECIDE, S_UP, S_DN, S_FIN, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEPT_W-1:0]   keep_r, keep_nxt;
  logic [SW-1:0]       size_r, size_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW-1:0]       par_r, par_nxt;
  logic [DIST_W-1:0]   top_r, top_nxt;
  logic                last_r, last_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [DIST_W-1:0]   ocut_r, ocut_nxt;
  logic [KEPT_W-1:0]   okept_r, okept_nxt;
  logic                olast_r, olast_nxt;

  logic [DIST_W-1:0]   mem [KEEP_MAX];
  logic [DIST_W-1:0]   rd0_r, rd1_r;
  logic                we;
  logic [AW-1:0]       wa, ra0, ra1;
  logic [DIST_W-1:0]   wd;

  logic [DIST_W-1:0]   dist_sq;
  logic                accept;
  logic [LW-1:0]       lim, keep_ext, size_ext;
  logic                full;
  logic [CW-1:0]       lc, rc, bc, nl, sz_c;
  logic [DIST_W-1:0]   bval;
  logic [AW-1:0]       up_nxt;
  logic [KEPT_W+SW-1:0] kept_ext;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  ksdc_sqdist u_sqdist (
    .clk     (clk),
    .load    (accept),
    .ax      (in_tdata[14:0]),
    .ay      (in_tdata[29:15]),
    .bx      (in_tdata[44:30]),
    .by      (in_tdata[59:45]),
    .dist_sq (dist_sq)
  );

  always_comb begin
    keep_ext = LW'(keep_r);
    size_ext = LW'(size_r);
    if (keep_ext == '0) begin
      lim = LW'(1);
    end else if (keep_ext > LW'(KEEP_MAX)) begin
      lim = LW'(KEEP_MAX);
    end else begin
      lim = keep_ext;
    end
    full = (size_ext >= lim) || (size_ext >= LW'(KEEP_MAX));
  end

  assign sz_c = CW'(size_r);
  assign lc   = {1'b0, pos_r, 1'b1};
  assign rc   = lc + CW'(1);
  always_comb begin
    if ((rc < sz_c) && (rd1_r > rd0_r)) begin
      bc   = rc;
      bval = rd1_r;
    end else begin
      bc   = lc;
      bval = rd0_r;
    end
  end
  assign nl     = {bc[CW-2:0], 1'b1};
  assign up_nxt = AW'((par_r - AW'(1)) >> 1);
  assign kept_ext = {{KEPT_W{1'b0}}, size_r};

  always_comb begin
    state_nxt  = state_r;
    keep_nxt   = keep_r;
    size_nxt   = size_r;
    pos_nxt    = pos_r;
    par_nxt    = par_r;
    top_nxt    = top_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    ocut_nxt   = ocut_r;
    okept_nxt  = okept_r;
    olast_nxt  = olast_r;
    we  = 1'b0;
    wa  = pos_r;
    wd  = dist_sq;
    ra0 = '0;
    ra1 = '0;

    if (cfg_valid && cfg_ready) begin
      keep_nxt = cfg_data;
    end
    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt  = in_tlast;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!full) begin
          size_nxt = size_r + SW'(1);
          if (size_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            pos_nxt   = AW'(size_r);
            par_nxt   = AW'((size_r - SW'(1)) >> 1);
            ra0       = AW'((size_r - SW'(1)) >> 1);
            state_nxt = S_UP;
          end
        end else if (dist_sq < top_r) begin
          pos_nxt = '0;
          if (size_r == SW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            ra0       = AW'(1);
            ra1       = AW'(2);
            state_nxt = S_DN;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_UP: begin
        if (rd0_r >= dist_sq) begin
          state_nxt = S_FIN;
        end else begin
          we      = 1'b1;
          wa      = pos_r;
          wd      = rd0_r;
          pos_nxt = par_r;
          if (par_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            par_nxt = up_nxt;
            ra0     = up_nxt;
          end
        end
      end
      S_DN: begin
        if (bval <= dist_sq) begin
          state_nxt = S_FIN;
        end else begin
          we      = 1'b1;
          wa      = pos_r;
          wd      = bval;
          if (pos_r == '0) begin
            top_nxt = bval;
          end
          pos_nxt = AW'(bc);
          if (nl >= sz_c) begin
            state_nxt = S_FIN;
          end else begin
            ra0 = AW'(nl);
            ra1 = AW'(nl + CW'(1));
          end
        end
      end
      S_FIN: begin
        we = 1'b1;
        wa = pos_r;
        wd = dist_sq;
        if (pos_r == '0) begin
          top_nxt = dist_sq;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ocut_nxt   = top_r;
          okept_nxt  = kept_ext[KEPT_W-1:0];
          olast_nxt  = last_r;
          if (last_r) begin
            size_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      keep_r   <= KEEP_RESET;
      size_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      keep_r   <= keep_nxt;
      size_r   <= size_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pos_r   <= pos_nxt;
    par_r   <= par_nxt;
    top_r   <= top_nxt;
    last_r  <= last_nxt;
    ocut_r  <= ocut_nxt;
    okept_r <= okept_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, okept_r, ocut_r};
  assign out_tlast  = olast_r;

endmodule

// File: sv/ksdc_sqdist.sv
// Squared Euclidean distance of two points: difference, square, sum stages.
module ksdc_sqdist (
  input  logic                    clk,
  input  logic                    load,
  input  logic [ksdc_pkg::COORD_W-1:0] ax,
  input  logic [ksdc_pkg::COORD_W-1:0] ay,
  input  logic [ksdc_pkg::COORD_W-1:0] bx,
  input  logic [ksdc_pkg::COORD_W-1:0] by,
  output logic [ksdc_pkg::DIST_W-1:0]  dist_sq
);
  import ksdc_pkg::*;

  logic [COORD_W-1:0] dx_r;
  logic [COORD_W-1:0] dy_r;
  logic [SQ_W-1:0]    sx_r;
  logic [SQ_W-1:0]    sy_r;
  logic [DIST_W-1:0]  dist_r;

  always_ff @(posedge clk) begin
    if (load) begin
      dx_r <= (ax > bx) ? (ax - bx) : (bx - ax);
      dy_r <= (ay > by) ? (ay - by) : (by - ay);
    end
    sx_r   <= dx_r * dx_r;
    sy_r   <= dy_r * dy_r;
    dist_r <= DIST_W'(sx_r) + DIST_W'(sy_r);
  end

  assign dist_sq = dist_r;

endmodule
